// ----- src/vpps_pkg.sv -----
// Shared types and constants for the vacuum purge phase sequencer.
package vpps_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] CSR_SPEED_TABLE       = 3'd0;
   localparam logic [2:0] CSR_PHASE_ONE_COLLECT = 3'd1;
   localparam logic [2:0] CSR_PHASE_ONE_PLASMA  = 3'd2;
   localparam logic [2:0] CSR_PHASE_TWO_PLASMA  = 3'd3;
   localparam logic [2:0] CSR_PHASE_THREE_PLASMA = 3'd4;
   localparam logic [2:0] CSR_PAUSE_LENGTH      = 3'd5;
   localparam logic [2:0] CSR_CYCLE_COUNT       = 3'd6;

   localparam logic [15:0] PAUSE_LENGTH_RESET = 16'd3000;
   localparam logic [3:0]  CYCLE_COUNT_RESET  = 4'd3;

   localparam logic [1:0] OP_STEP    = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic signed [23:0] TOTAL_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] TOTAL_MIN = -24'sh800000;
   localparam logic [4:0] CYCLE_MAX = 5'd31;

   typedef enum logic [1:0] {
      CMD_STEP,
      CMD_TICK,
      CMD_RESTART,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      PH_ONE,
      PH_TWO,
      PH_THREE,
      PH_WRAP
   } phase_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [11:0] collect_delta;
      logic signed [11:0] plasma_delta;
   } cmd_type;

   typedef struct packed {
      logic [59:0] speed_table;
      logic [19:0] phase_one_collect_volume;
      logic [19:0] phase_one_plasma_volume;
      logic [19:0] phase_two_plasma_volume;
      logic [19:0] phase_three_plasma_volume;
      logic [15:0] pause_length;
      logic [3:0]  cycle_count;
   } cfg_type;

endpackage

// ----- src/vpps_csr.sv -----
// Configuration register file behind the APB-style port.
module vpps_csr
   import vpps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       write_en;

   assign index      = csr_paddr[5:3];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_SPEED_TABLE:        cfg_in.speed_table = csr_pwdata[59:0];
            CSR_PHASE_ONE_COLLECT:  cfg_in.phase_one_collect_volume = csr_pwdata[19:0];
            CSR_PHASE_ONE_PLASMA:   cfg_in.phase_one_plasma_volume = csr_pwdata[19:0];
            CSR_PHASE_TWO_PLASMA:   cfg_in.phase_two_plasma_volume = csr_pwdata[19:0];
            CSR_PHASE_THREE_PLASMA: cfg_in.phase_three_plasma_volume = csr_pwdata[19:0];
            CSR_PAUSE_LENGTH:       cfg_in.pause_length = csr_pwdata[15:0];
            CSR_CYCLE_COUNT:        cfg_in.cycle_count = csr_pwdata[3:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_SPEED_TABLE:        csr_prdata = {4'd0, cfg_ff.speed_table};
         CSR_PHASE_ONE_COLLECT:  csr_prdata = {44'd0, cfg_ff.phase_one_collect_volume};
         CSR_PHASE_ONE_PLASMA:   csr_prdata = {44'd0, cfg_ff.phase_one_plasma_volume};
         CSR_PHASE_TWO_PLASMA:   csr_prdata = {44'd0, cfg_ff.phase_two_plasma_volume};
         CSR_PHASE_THREE_PLASMA: csr_prdata = {44'd0, cfg_ff.phase_three_plasma_volume};
         CSR_PAUSE_LENGTH:       csr_prdata = {48'd0, cfg_ff.pause_length};
         CSR_CYCLE_COUNT:        csr_prdata = {60'd0, cfg_ff.cycle_count};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_table               <= '0;
         cfg_ff.phase_one_collect_volume  <= '0;
         cfg_ff.phase_one_plasma_volume   <= '0;
         cfg_ff.phase_two_plasma_volume   <= '0;
         cfg_ff.phase_three_plasma_volume <= '0;
         cfg_ff.pause_length              <= PAUSE_LENGTH_RESET;
         cfg_ff.cycle_count               <= CYCLE_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/vpps_front.sv -----
// Request intake: classifies each transaction and queues it for execution.
module vpps_front
   import vpps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [11:0] req_collect_delta,
   input  logic signed [11:0] req_plasma_delta,
   output logic               head_valid,
   output cmd_type            head_cmd,
   input  logic               head_pop
);

   cmd_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;
   cmd_type                new_cmd;

   always_comb begin
      case (req_op)
         OP_STEP:    new_cmd.kind = CMD_STEP;
         OP_TICK:    new_cmd.kind = CMD_TICK;
         OP_RESTART: new_cmd.kind = CMD_RESTART;
         default:    new_cmd.kind = CMD_NOP;
      endcase
      new_cmd.collect_delta = req_collect_delta;
      new_cmd.plasma_delta  = req_plasma_delta;
   end

   assign req_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = queue_ff[rd_ptr_ff];
   assign push       = req_valid & req_ready;
   assign pop        = head_pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- src/vpps_back.sv -----
// Execution unit: volume totals, phase sequencing, pause timer and result register.
module vpps_back
   import vpps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        head_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_collect_speed,
   output logic [9:0]  rsp_plasma_speed,
   output logic [1:0]  rsp_phase,
   output logic [4:0]  rsp_cycle_number,
   output logic        rsp_paused,
   output logic        rsp_finished
);

   logic               stage_valid_ff;
   logic               stage_valid_in;
   cmd_kind_type       stage_kind_ff;
   logic signed [23:0] sum_c_ff;
   logic signed [23:0] sum_p_ff;
   logic signed [24:0] raw_c;
   logic signed [24:0] raw_p;
   logic signed [23:0] sat_c;
   logic signed [23:0] sat_p;

   logic signed [23:0] collect_total_ff, collect_total_in;
   logic signed [23:0] plasma_total_ff, plasma_total_in;
   phase_type          phase_ff, phase_in;
   logic [4:0]         cycle_ff, cycle_in;
   logic [15:0]        pause_rem_ff, pause_rem_in;
   logic               pause_act_ff, pause_act_in;
   logic               third_ff, third_in;
   logic               two_ff, two_in;
   logic               done_ff, done_in;
   logic [9:0]         held_c_ff, held_c_in;
   logic [9:0]         held_p_ff, held_p_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_c_ff, rsp_p_ff;
   logic [1:0]         rsp_phase_ff;
   logic [4:0]         rsp_cycle_ff;
   logic               rsp_paused_ff, rsp_finished_ff;

   logic               commit;
   logic signed [26:0] p3;
   logic signed [26:0] thr3;
   logic signed [26:0] thr3x2;
   logic [9:0]         tab_c;
   logic [9:0]         tab_p;
   logic [15:0]        rem_dec;

   assign head_pop = head_valid & ~stage_valid_ff;
   assign commit   = stage_valid_ff & (~rsp_valid_ff | rsp_ready);

   // stage one: saturating volume sums
   always_comb begin
      raw_c = {collect_total_ff[23], collect_total_ff}
            + {{13{head_cmd.collect_delta[11]}}, head_cmd.collect_delta};
      raw_p = {plasma_total_ff[23], plasma_total_ff}
            + {{13{head_cmd.plasma_delta[11]}}, head_cmd.plasma_delta};
      if (raw_c[24] != raw_c[23]) begin
         sat_c = raw_c[24] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
         sat_c = raw_c[23:0];
      end
      if (raw_p[24] != raw_p[23]) begin
         sat_p = raw_p[24] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
         sat_p = raw_p[23:0];
      end
   end

   always_comb begin
      case (phase_ff)
         PH_ONE: begin
            tab_c = cfg.speed_table[9:0];
            tab_p = cfg.speed_table[19:10];
         end
         PH_TWO: begin
            tab_c = cfg.speed_table[29:20];
            tab_p = cfg.speed_table[39:30];
         end
         PH_THREE: begin
            tab_c = cfg.speed_table[49:40];
            tab_p = cfg.speed_table[59:50];
         end
         default: begin
            tab_c = held_c_ff;
            tab_p = held_p_ff;
         end
      endcase
   end

   assign p3      = {{3{sum_p_ff[23]}}, sum_p_ff} + {{2{sum_p_ff[23]}}, sum_p_ff, 1'b0};
   assign thr3    = {7'd0, cfg.phase_three_plasma_volume};
   assign thr3x2  = {6'd0, cfg.phase_three_plasma_volume, 1'b0};
   assign rem_dec = (pause_rem_ff != '0) ? pause_rem_ff - 1'b1 : pause_rem_ff;

   // stage two: phase update
   always_comb begin
      collect_total_in = collect_total_ff;
      plasma_total_in  = plasma_total_ff;
      phase_in         = phase_ff;
      cycle_in         = cycle_ff;
      pause_rem_in     = pause_rem_ff;
      pause_act_in     = pause_act_ff;
      third_in         = third_ff;
      two_in           = two_ff;
      done_in          = done_ff;
      held_c_in        = held_c_ff;
      held_p_in        = held_p_ff;
      if (commit) begin
         case (stage_kind_ff)
            CMD_RESTART: begin
               collect_total_in = '0;
               plasma_total_in  = '0;
               phase_in         = PH_ONE;
               cycle_in         = 5'd1;
               pause_rem_in     = '0;
               pause_act_in     = 1'b0;
               third_in         = 1'b0;
               two_in           = 1'b0;
               done_in          = 1'b0;
               held_c_in        = '0;
               held_p_in        = '0;
            end
            CMD_TICK: begin
               if (!done_ff && pause_act_ff) begin
                  pause_rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     pause_act_in = 1'b0;
                  end
               end
            end
            CMD_STEP: begin
               if (!done_ff) begin
                  if (pause_act_ff) begin
                     held_c_in = '0;
                     held_p_in = '0;
                  end else begin
                     held_c_in        = tab_c;
                     held_p_in        = tab_p;
                     collect_total_in = sum_c_ff;
                     plasma_total_in  = sum_p_ff;
                     case (phase_ff)
                        PH_ONE: begin
                           if ($signed({sum_c_ff[23], sum_c_ff})
                                  >= $signed({5'd0, cfg.phase_one_collect_volume})
                               && $signed({sum_p_ff[23], sum_p_ff})
                                  >= $signed({5'd0, cfg.phase_one_plasma_volume})) begin
                              phase_in         = PH_TWO;
                              collect_total_in = '0;
                              plasma_total_in  = '0;
                           end
                        end
                        PH_TWO: begin
                           if ($signed({sum_p_ff[23], sum_p_ff})
                                  >= $signed({5'd0, cfg.phase_two_plasma_volume})) begin
                              phase_in         = PH_THREE;
                              collect_total_in = '0;
                              plasma_total_in  = '0;
                              if (cfg.pause_length != '0) begin
                                 pause_act_in = 1'b1;
                                 pause_rem_in = cfg.pause_length;
                              end
                           end
                        end
                        PH_THREE: begin
                           if (cfg.pause_length != '0) begin
                              if (p3 >= thr3 && !third_ff) begin
                                 third_in     = 1'b1;
                                 pause_act_in = 1'b1;
                                 pause_rem_in = cfg.pause_length;
                              end
                              if (p3 >= thr3x2 && !two_ff) begin
                                 two_in       = 1'b1;
                                 pause_act_in = 1'b1;
                                 pause_rem_in = cfg.pause_length;
                              end
                           end
                           if ($signed({3'd0, sum_p_ff}) >= thr3 && !sum_p_ff[23]) begin
                              phase_in         = PH_WRAP;
                              collect_total_in = '0;
                              plasma_total_in  = '0;
                              third_in         = 1'b0;
                              two_in           = 1'b0;
                           end
                        end
                        default: begin
                           if (cycle_ff < CYCLE_MAX) begin
                              cycle_in = cycle_ff + 1'b1;
                           end
                           phase_in = PH_ONE;
                        end
                     endcase
                  end
                  if (cycle_in > {1'b0, cfg.cycle_count}) begin
                     done_in      = 1'b1;
                     pause_act_in = 1'b0;
                     pause_rem_in = '0;
                     held_c_in    = '0;
                     held_p_in    = '0;
                  end
               end
            end
            default: begin
               done_in = done_ff;
            end
         endcase
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (head_pop) begin
         stage_valid_in = 1'b1;
      end else if (commit) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         collect_total_ff <= '0;
         plasma_total_ff  <= '0;
         phase_ff         <= PH_ONE;
         cycle_ff         <= 5'd1;
         pause_rem_ff     <= '0;
         pause_act_ff     <= 1'b0;
         third_ff         <= 1'b0;
         two_ff           <= 1'b0;
         done_ff          <= 1'b0;
         held_c_ff        <= '0;
         held_p_ff        <= '0;
      end else begin
         stage_valid_ff   <= stage_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         collect_total_ff <= collect_total_in;
         plasma_total_ff  <= plasma_total_in;
         phase_ff         <= phase_in;
         cycle_ff         <= cycle_in;
         pause_rem_ff     <= pause_rem_in;
         pause_act_ff     <= pause_act_in;
         third_ff         <= third_in;
         two_ff           <= two_in;
         done_ff          <= done_in;
         held_c_ff        <= held_c_in;
         held_p_ff        <= held_p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         stage_kind_ff <= head_cmd.kind;
         sum_c_ff      <= sat_c;
         sum_p_ff      <= sat_p;
      end
      if (commit) begin
         rsp_c_ff        <= done_in ? 10'd0 : held_c_in;
         rsp_p_ff        <= done_in ? 10'd0 : held_p_in;
         rsp_phase_ff    <= (phase_in == PH_WRAP) ? 2'd1 : 2'(phase_in) + 2'd1;
         rsp_cycle_ff    <= cycle_in;
         rsp_paused_ff   <= pause_act_in;
         rsp_finished_ff <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_collect_speed = rsp_c_ff;
   assign rsp_plasma_speed  = rsp_p_ff;
   assign rsp_phase         = rsp_phase_ff;
   assign rsp_cycle_number  = rsp_cycle_ff;
   assign rsp_paused        = rsp_paused_ff;
   assign rsp_finished      = rsp_finished_ff;

   a_finish_zero_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_finished_ff |-> rsp_c_ff == '0 && rsp_p_ff == '0)
      else $error("finished result carries nonzero speed");

   a_finish_not_paused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_finished_ff |-> !rsp_paused_ff)
      else $error("finished result reports a pause");

   a_pop_stage_free: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> stage_valid_ff && !$past(stage_valid_ff))
      else $error("queue popped into an occupied stage");

   a_cycle_nonzero: assert property (@(posedge clock) disable iff (reset)
      cycle_ff != '0)
      else $error("cycle number dropped to zero");

endmodule

// ----- src/vacuum_purge_phase_sequencer.sv -----
// Top level of the three-phase vacuum purge sequencer.
// Usage:
//  - req channel (valid/ready) carries one transaction: op, collect_delta,
//    plasma_delta. op 0 is a control step, 1 a millisecond tick, 2 enter or restart.
//  - rsp channel (valid/ready) returns one transaction per request, in order:
//    pump speeds, phase, cycle number, paused and finished flags.
//  - csr port (APB style, 64-bit data) holds the speed table, volume thresholds,
//    pause length and cycle count at byte addresses 8*i; write only while idle.
// Timing:
//  - a request is queued on acceptance, then loaded into the execution stage once
//    that stage is free, and its result is registered once the result register can
//    take it; rsp_valid rises when the result is registered.
//  - the execution stage takes a new transaction only after the one it holds has
//    committed, so transactions pass its sum and commit sequence one at a time.
//  - a 2-entry queue sits between intake and execution; req_ready drops when full.
// Reset:
//  - synchronous; clears queue, sequencer state (phase one, cycle one, no pause)
//    and restores register defaults (pause 3000, cycle count 3).
// Stall:
//  - while rsp_ready is low the result register holds, execution waits and the
//    queue fills, then req_ready deasserts.
module vacuum_purge_phase_sequencer
   import vpps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic signed [11:0]    req_collect_delta,
   input  logic signed [11:0]    req_plasma_delta,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [9:0]            rsp_collect_speed,
   output logic [9:0]            rsp_plasma_speed,
   output logic [1:0]            rsp_phase,
   output logic [4:0]            rsp_cycle_number,
   output logic                  rsp_paused,
   output logic                  rsp_finished,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   vpps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vpps_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_collect_delta (req_collect_delta),
      .req_plasma_delta  (req_plasma_delta),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .head_pop          (head_pop)
   );

   vpps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_collect_speed (rsp_collect_speed),
      .rsp_plasma_speed  (rsp_plasma_speed),
      .rsp_phase         (rsp_phase),
      .rsp_cycle_number  (rsp_cycle_number),
      .rsp_paused        (rsp_paused),
      .rsp_finished      (rsp_finished)
   );

endmodule
